FILE: src/msspc_pkg.sv
// Package for the strict saddle point checker.
// Holds default sizes, reset values, register indexes and the control state type.
// No dependencies.
package msspc_pkg;

  localparam int MAX_DIM_DEF    = 16;
  localparam int VALUE_BITS_DEF = 16;

  localparam int DIM_REG_BITS  = 5;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 8;
  localparam int OUT_DATA_BITS = 8;

  localparam logic [DIM_REG_BITS-1:0] ROW_COUNT_RST = 5'd10;
  localparam logic [DIM_REG_BITS-1:0] COL_COUNT_RST = 5'd10;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_COUNT = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COL_COUNT = 8'd1;

  typedef enum logic {
    ST_LOAD,
    ST_WALK
  } state_t;

endpackage

FILE: src/msspc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during a write to the same address returns the old contents.
// No dependencies.
module msspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/matrix_strict_saddle_point_check.sv
// Strict saddle point checker: takes a matrix one element per word in row-major
// order and, after the last element, returns one word telling whether some element
// is strictly the largest of its row and strictly the smallest of its column.
// Loading runs at one element per cycle; the column minima are kept in a RAM and
// updated read-modify-write, the row winners in a second RAM. After the last
// element the input stalls while the columns are walked, and longer while an
// earlier result word still waits: each step reads the column RAM and then the
// row winner RAM at the row that column's minimum came from. A write to the row
// or column count restarts the matrix.
// Depends on msspc_pkg and msspc_ram.
module matrix_strict_saddle_point_check #(
  parameter int MAX_DIM    = msspc_pkg::MAX_DIM_DEF,
  parameter int VALUE_BITS = msspc_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: [VALUE_BITS-1:0] element_value, rest zero
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] in_tdata,
  // out_tdata: [0] found, rest zero
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [msspc_pkg::OUT_DATA_BITS-1:0]   out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [msspc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [msspc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int IDXW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNTW = $clog2(MAX_DIM + 1);
  localparam int REGW = msspc_pkg::DIM_REG_BITS;
  localparam int CMPW = (CNTW > REGW) ? CNTW : REGW;
  localparam int CEW  = VALUE_BITS + IDXW + 1;

  msspc_pkg::state_t state_r, state_nxt;

  logic [REGW-1:0] row_count_r, col_count_r;
  logic [IDXW-1:0] cur_row_r, cur_col_r;
  logic [CNTW-1:0] rows_eff, cols_eff;

  logic                         s1_valid_r;
  logic signed [VALUE_BITS-1:0] s1_val_r;
  logic [IDXW-1:0]              s1_row_r, s1_col_r;
  logic                         s1_row_end_r;

  logic signed [VALUE_BITS-1:0] peak_val_r, peak_val_nxt;
  logic [IDXW-1:0]              peak_col_r, peak_col_nxt;
  logic                         peak_uniq_r, peak_uniq_nxt;

  logic            col_we;
  logic [IDXW-1:0] col_raddr;
  logic [CEW-1:0]  col_wdata, col_rdata, col_eff;
  logic            fwd_r;
  logic [CEW-1:0]  fwd_data_r;

  logic signed [VALUE_BITS-1:0] eff_val;
  logic [IDXW-1:0]              eff_row;
  logic                         eff_uniq;

  logic            rw_we;
  logic [CNTW-1:0] rw_wdata, rw_rdata;

  logic [CNTW-1:0] k_r;
  logic            walk_issue, walk_done, out_free, hit;
  logic            w1_valid_r, w2_valid_r, w2_uniq_r;
  logic [CNTW-1:0] w1_k_r, w2_k_r;
  logic            found_acc_r;
  logic            out_valid_r, out_found_r;

  logic in_acc, cfg_acc, col_last, row_last;

  function automatic logic [CNTW-1:0] clamp_dim(input logic [REGW-1:0] d);
    logic [CMPW-1:0] ext;
    ext = CMPW'(d);
    if (ext == '0) begin
      return CNTW'(1);
    end else if (ext > CMPW'(MAX_DIM)) begin
      return CNTW'(MAX_DIM);
    end
    return ext[CNTW-1:0];
  endfunction

  assign rows_eff = clamp_dim(row_count_r);
  assign cols_eff = clamp_dim(col_count_r);

  assign in_tready  = (state_r == msspc_pkg::ST_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign cfg_acc    = cfg_valid;
  assign col_last   = !((CNTW'(cur_col_r) + CNTW'(1)) < cols_eff);
  assign row_last   = !((CNTW'(cur_row_r) + CNTW'(1)) < rows_eff);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(msspc_pkg::OUT_DATA_BITS - 1){1'b0}}, out_found_r};
  assign out_free   = !out_valid_r || out_tready;

  // column entry: {unique, row, value}
  assign col_eff  = fwd_r ? fwd_data_r : col_rdata;
  assign eff_val  = $signed(col_eff[VALUE_BITS-1:0]);
  assign eff_row  = col_eff[VALUE_BITS+IDXW-1:VALUE_BITS];
  assign eff_uniq = col_eff[CEW-1];

  always_comb begin
    peak_val_nxt  = peak_val_r;
    peak_col_nxt  = peak_col_r;
    peak_uniq_nxt = peak_uniq_r;
    if (s1_col_r == '0 || s1_val_r > peak_val_r) begin
      peak_val_nxt  = s1_val_r;
      peak_col_nxt  = s1_col_r;
      peak_uniq_nxt = 1'b1;
    end else if (s1_val_r == peak_val_r) begin
      peak_uniq_nxt = 1'b0;
    end
  end

  always_comb begin
    col_wdata = col_eff;
    if (s1_row_r == '0 || s1_val_r < eff_val) begin
      col_wdata = {1'b1, s1_row_r, s1_val_r};
    end else if (s1_val_r == eff_val) begin
      col_wdata = {1'b0, eff_row, eff_val};
    end
  end

  assign col_we    = s1_valid_r;
  assign col_raddr = (state_r == msspc_pkg::ST_WALK) ? k_r[IDXW-1:0] : cur_col_r;
  assign rw_we     = s1_valid_r && s1_row_end_r;
  assign rw_wdata  = peak_uniq_nxt ? (CNTW'(peak_col_nxt) + CNTW'(1)) : '0;

  assign walk_issue = (state_r == msspc_pkg::ST_WALK) && (k_r < cols_eff);
  assign walk_done  = (state_r == msspc_pkg::ST_WALK) && !walk_issue &&
                      !w1_valid_r && !w2_valid_r;
  assign hit        = w2_valid_r && w2_uniq_r && (rw_rdata == w2_k_r + CNTW'(1));

  msspc_ram #(.WIDTH(CEW), .DEPTH(MAX_DIM)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (s1_col_r),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  msspc_ram #(.WIDTH(CNTW), .DEPTH(MAX_DIM)) u_rw_ram (
    .clk   (clk),
    .we    (rw_we),
    .waddr (s1_row_r),
    .wdata (rw_wdata),
    .raddr (eff_row),
    .rdata (rw_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msspc_pkg::ST_LOAD: begin
        if (in_acc && col_last && row_last) begin
          state_nxt = msspc_pkg::ST_WALK;
        end
      end
      msspc_pkg::ST_WALK: begin
        if (walk_done && out_free) begin
          state_nxt = msspc_pkg::ST_LOAD;
        end
      end
      default: state_nxt = msspc_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msspc_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= msspc_pkg::ROW_COUNT_RST;
      col_count_r <= msspc_pkg::COL_COUNT_RST;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      w1_valid_r  <= 1'b0;
      w2_valid_r  <= 1'b0;
      k_r         <= '0;
      found_acc_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      fwd_r      <= col_we && (s1_col_r == col_raddr);
      w1_valid_r <= walk_issue;
      w2_valid_r <= w1_valid_r;

      if (cfg_acc) begin
        if (cfg_index == msspc_pkg::CFG_ROW_COUNT) begin
          row_count_r <= cfg_data[REGW-1:0];
          cur_row_r   <= '0;
          cur_col_r   <= '0;
        end else if (cfg_index == msspc_pkg::CFG_COL_COUNT) begin
          col_count_r <= cfg_data[REGW-1:0];
          cur_row_r   <= '0;
          cur_col_r   <= '0;
        end
      end else if (in_acc) begin
        if (!col_last) begin
          cur_col_r <= cur_col_r + IDXW'(1);
        end else begin
          cur_col_r <= '0;
          cur_row_r <= row_last ? '0 : cur_row_r + IDXW'(1);
        end
      end

      if (in_acc && col_last && row_last) begin
        k_r         <= '0;
        found_acc_r <= 1'b0;
      end else begin
        if (walk_issue) begin
          k_r <= k_r + CNTW'(1);
        end
        if (hit) begin
          found_acc_r <= 1'b1;
        end
      end

      if (walk_done && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= col_wdata;
    w1_k_r     <= k_r;
    w2_k_r     <= w1_k_r;
    w2_uniq_r  <= eff_uniq;
    if (in_acc) begin
      s1_val_r     <= $signed(in_tdata[VALUE_BITS-1:0]);
      s1_row_r     <= cur_row_r;
      s1_col_r     <= cur_col_r;
      s1_row_end_r <= col_last;
    end
    if (s1_valid_r) begin
      peak_val_r  <= peak_val_nxt;
      peak_col_r  <= peak_col_nxt;
      peak_uniq_r <= peak_uniq_nxt;
    end
    if (walk_done && out_free) begin
      out_found_r <= found_acc_r;
    end
  end

endmodule

FILE: src/msspc_checker.sv
// Port-level checks for the strict saddle point checker, bound to its top level.
// Depends on msspc_pkg and matrix_strict_saddle_point_check.
module msspc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [msspc_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed or dropped while stalled");

  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[msspc_pkg::OUT_DATA_BITS-1:1] == '0)
    else $error("result padding bits not zero");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a column walk");

endmodule

bind matrix_strict_saddle_point_check msspc_checker u_msspc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
